### rtl/tlba_pkg.sv
// shared types, constants and helper functions of the two-level bitmap block allocator
`default_nettype none

package tlba_pkg;

	localparam int NUM_GROUPS_DEF = 32;
	localparam int MAX_BLOCKS_DEF = 1024;

	localparam int ADDR_W = 32;
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;
	localparam int SIZE_W = 13;
	localparam int CNT_W  = 11;
	localparam int PROD_W = SIZE_W + CNT_W;

	localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(32);

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_RANGE  = 2'd2,
		ST_DOUBLE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_POOL_BASE   = 2'd0,
		REG_BLOCK_SIZE  = 2'd1,
		REG_BLOCK_COUNT = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ARD,
		S_AWB,
		S_MUL,
		S_AADR,
		S_FCHK,
		S_FDIV,
		S_FWB
	} state_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] blk_addr;
		logic [CNT_W-1:0]  free_blocks;
	} rsp_t;

	// index of the highest set bit, zero for an empty word
	function automatic logic [BIT_W-1:0] hi_bit(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

	// free bits of one group word right after the pool is loaded with n blocks
	function automatic logic [WORD_W-1:0] init_word(input logic [CNT_W-1:0] n,
		input logic [BIT_W-1:0] g);
		logic [CNT_W-1:0] first;
		logic [CNT_W-1:0] diff;
		logic [WORD_W-1:0] w;
		first = CNT_W'(g) << BIT_W;
		diff  = n - first;
		if (n >= first + CNT_W'(WORD_W)) begin
			w = '1;
		end else if (n > first) begin
			w = (WORD_W'(1) << diff[BIT_W-1:0]) - WORD_W'(1);
		end else begin
			w = '0;
		end
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/tlba_div.sv
// restoring divider producing a short quotient one bit per cycle
`default_nettype none

module tlba_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [tlba_pkg::PROD_W-1:0]  dividend,
	input  wire logic [tlba_pkg::SIZE_W-1:0]  divisor,
	output logic                              done,
	output logic [tlba_pkg::CNT_W-1:0]        quotient
);

	localparam int PROD_W = tlba_pkg::PROD_W;
	localparam int CNT_W  = tlba_pkg::CNT_W;
	localparam int STEP_W = $clog2(CNT_W);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [PROD_W-1:0] rem_q;
	logic [PROD_W-1:0] dsr_q;
	logic [CNT_W-1:0]  quo_q;
	logic              ge;

	assign ge       = rem_q >= dsr_q;
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= run_q && (step_q == '0);
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(CNT_W - 1);
			end else if (run_q) begin
				if (step_q == '0) begin
					run_q <= 1'b0;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	// dividend is below divisor * 2^CNT_W, so CNT_W steps suffice
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= PROD_W'(divisor) << (CNT_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dsr_q;
			end
			dsr_q <= dsr_q >> 1;
			quo_q <= {quo_q[CNT_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

### rtl/two_level_bitmap_block_allocator.sv
// top level of the two-level bitmap fixed-size block allocator
//
// A request is taken when start is high and busy is low. cmd selects allocate or
// free; free_address is used only by a free. Every request gives exactly one
// result, shown on rsp for one cycle with done high; the receiver cannot hold it.
// Allocate runs from the accepting edge to done through the summary priority
// encode with the group word read, the write-back, the size * index multiply and
// the base add; an empty pool answers at the encode step. Free runs through the
// size * count range multiply, the range compare, the bit-serial quotient
// divider, its done flag with the word read, and the write-back; an out-of-range
// free answers at the range compare. One request is in flight at a time; busy is
// high until its result is registered, and the next request may be accepted in
// the cycle done is high.
// The group words sit in a single-port synchronous memory; each has a valid flag
// so an entry that has not been written since reset or the last block_count
// write reads as its freshly loaded value. Reset and a block_count write reload
// the pool at once, with no clearing pass. Configuration writes on cfg_we are
// taken at any edge but belong to idle periods.
`default_nettype none

module two_level_bitmap_block_allocator #(
	parameter int NUM_GROUPS = tlba_pkg::NUM_GROUPS_DEF,
	parameter int MAX_BLOCKS = tlba_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire tlba_pkg::req_t               req,
	output logic                              done,
	output tlba_pkg::rsp_t                    rsp,
	input  wire logic                         cfg_we,
	input  wire logic [1:0]                   cfg_idx,
	input  wire logic [tlba_pkg::ADDR_W-1:0]  cfg_wdata
);

	localparam int ADDR_W = tlba_pkg::ADDR_W;
	localparam int WORD_W = tlba_pkg::WORD_W;
	localparam int BIT_W  = tlba_pkg::BIT_W;
	localparam int SIZE_W = tlba_pkg::SIZE_W;
	localparam int CNT_W  = tlba_pkg::CNT_W;
	localparam int PROD_W = tlba_pkg::PROD_W;
	localparam int GW     = $clog2(NUM_GROUPS);
	localparam int IW     = GW + BIT_W;
	localparam int CAP_I  = (MAX_BLOCKS < WORD_W * NUM_GROUPS) ? MAX_BLOCKS
		: WORD_W * NUM_GROUPS;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_I);

	function automatic logic [NUM_GROUPS-1:0] grp_init(input logic [CNT_W-1:0] n);
		logic [NUM_GROUPS-1:0] s;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			s[g] = n > CNT_W'(g * WORD_W);
		end
		return s;
	endfunction

	tlba_pkg::state_t       state_q, state_d;
	tlba_pkg::cmd_t         cmd_q;
	tlba_pkg::rsp_t         rsp_q, res_d;
	logic                   done_q, res_fire;

	logic [ADDR_W-1:0]      base_q;
	logic [SIZE_W-1:0]      size_q;
	logic [CNT_W-1:0]       n_q, n_new;
	logic [NUM_GROUPS-1:0]  sum_q, vld_q;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic                   sum_set, sum_clr;

	logic [ADDR_W-1:0]      offset_q;
	logic [GW-1:0]          grp_q, top_grp, rd_a;
	logic [IW-1:0]          idx_q;
	logic [PROD_W-1:0]      prod_q;
	logic [CNT_W-1:0]       mul_b;

	logic [WORD_W-1:0]      mem [NUM_GROUPS];
	logic [WORD_W-1:0]      rd_q, word, clr_word, set_word, mem_wd;
	logic                   mem_we;
	logic [BIT_W-1:0]       blk_b, free_b;
	logic                   out_of_range;

	logic                   div_start, div_done;
	logic [CNT_W-1:0]       div_quo;

	assign busy = state_q != tlba_pkg::S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	assign n_new = (cfg_wdata[CNT_W-1:0] < CAP) ? cfg_wdata[CNT_W-1:0] : CAP;

	assign top_grp  = GW'(tlba_pkg::hi_bit(WORD_W'(sum_q)));
	assign word     = vld_q[grp_q] ? rd_q : tlba_pkg::init_word(n_q, BIT_W'(grp_q));
	assign blk_b    = tlba_pkg::hi_bit(word);
	assign clr_word = word & ~(WORD_W'(1) << blk_b);
	assign free_b   = idx_q[BIT_W-1:0];
	assign set_word = word | (WORD_W'(1) << free_b);
	assign mul_b    = (cmd_q == tlba_pkg::CMD_ALLOC) ? CNT_W'(idx_q) : n_q;
	assign out_of_range = offset_q >= ADDR_W'(prod_q);

	tlba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (offset_q[PROD_W-1:0]),
		.divisor  (size_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlba_pkg::S_IDLE: begin
				if (start) begin
					state_d = (req.cmd == tlba_pkg::CMD_ALLOC) ? tlba_pkg::S_ARD
						: tlba_pkg::S_MUL;
				end
			end
			tlba_pkg::S_ARD:  state_d = (sum_q == '0) ? tlba_pkg::S_IDLE : tlba_pkg::S_AWB;
			tlba_pkg::S_AWB:  state_d = tlba_pkg::S_MUL;
			tlba_pkg::S_MUL: begin
				state_d = (cmd_q == tlba_pkg::CMD_ALLOC) ? tlba_pkg::S_AADR
					: tlba_pkg::S_FCHK;
			end
			tlba_pkg::S_AADR: state_d = tlba_pkg::S_IDLE;
			tlba_pkg::S_FCHK: state_d = out_of_range ? tlba_pkg::S_IDLE : tlba_pkg::S_FDIV;
			tlba_pkg::S_FDIV: begin
				if (div_done) begin
					state_d = tlba_pkg::S_FWB;
				end
			end
			tlba_pkg::S_FWB:  state_d = tlba_pkg::S_IDLE;
			default:          state_d = tlba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		res_fire  = 1'b0;
		res_d     = '{status: tlba_pkg::ST_OK, blk_addr: '0, free_blocks: cnt_q};
		mem_we    = 1'b0;
		mem_wd    = clr_word;
		sum_set   = 1'b0;
		sum_clr   = 1'b0;
		cnt_d     = cnt_q;
		div_start = 1'b0;
		rd_a      = grp_q;
		unique case (state_q)
			tlba_pkg::S_ARD: begin
				rd_a = top_grp;
				if (sum_q == '0) begin
					res_fire     = 1'b1;
					res_d.status = tlba_pkg::ST_EMPTY;
				end
			end
			tlba_pkg::S_AWB: begin
				mem_we  = 1'b1;
				sum_clr = clr_word == '0;
				if (cnt_q != '0) begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			tlba_pkg::S_AADR: begin
				res_fire       = 1'b1;
				res_d.blk_addr = base_q + ADDR_W'(prod_q);
			end
			tlba_pkg::S_FCHK: begin
				if (out_of_range) begin
					res_fire     = 1'b1;
					res_d.status = tlba_pkg::ST_RANGE;
				end else begin
					div_start = 1'b1;
				end
			end
			tlba_pkg::S_FDIV: begin
				rd_a = div_quo[IW-1:BIT_W];
			end
			tlba_pkg::S_FWB: begin
				res_fire = 1'b1;
				if (word[free_b]) begin
					res_d.status = tlba_pkg::ST_DOUBLE;
				end else begin
					mem_we  = 1'b1;
					mem_wd  = set_word;
					sum_set = 1'b1;
					if (cnt_q != '1) begin
						cnt_d = cnt_q + CNT_W'(1);
					end
					res_d.free_blocks = cnt_d;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlba_pkg::S_IDLE;
			done_q  <= 1'b0;
			base_q  <= '0;
			size_q  <= tlba_pkg::SIZE_RST;
			n_q     <= CAP;
			sum_q   <= grp_init(CAP);
			vld_q   <= '0;
			cnt_q   <= CAP;
		end else begin
			state_q <= state_d;
			done_q  <= res_fire;
			if (cfg_we && cfg_idx == tlba_pkg::REG_BLOCK_COUNT) begin
				n_q   <= n_new;
				sum_q <= grp_init(n_new);
				vld_q <= '0;
				cnt_q <= n_new;
			end else begin
				if (mem_we) begin
					vld_q[grp_q] <= 1'b1;
				end
				if (sum_set) begin
					sum_q[grp_q] <= 1'b1;
				end else if (sum_clr) begin
					sum_q[grp_q] <= 1'b0;
				end
				cnt_q <= cnt_d;
			end
			if (cfg_we) begin
				unique case (cfg_idx)
					tlba_pkg::REG_POOL_BASE: base_q <= cfg_wdata;
					tlba_pkg::REG_BLOCK_SIZE: begin
						size_q <= (cfg_wdata[SIZE_W-1:0] == '0) ? SIZE_W'(1)
							: cfg_wdata[SIZE_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			rsp_q <= res_d;
		end
		if (state_q == tlba_pkg::S_IDLE && start) begin
			cmd_q    <= req.cmd;
			offset_q <= req.free_address - base_q;
		end
		if (state_q == tlba_pkg::S_ARD) begin
			grp_q <= top_grp;
		end
		if (state_q == tlba_pkg::S_AWB) begin
			idx_q <= {grp_q, blk_b};
		end
		if (state_q == tlba_pkg::S_FDIV && div_done) begin
			idx_q <= div_quo[IW-1:0];
			grp_q <= div_quo[IW-1:BIT_W];
		end
		if (state_q == tlba_pkg::S_MUL) begin
			prod_q <= PROD_W'(size_q) * PROD_W'(mul_b);
		end
	end

	// group word memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[grp_q] <= mem_wd;
		end
		rd_q <= mem[rd_a];
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	a_fell_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request finished without a result transfer");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != tlba_pkg::ST_OK) |-> rsp.blk_addr == '0)
		else $error("nonzero address on a failed request");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == tlba_pkg::S_FDIV)
		else $error("divider finished outside the quotient wait");

endmodule

`default_nettype wire

### test/tlba_result_check.sv
// result checker for the two-level bitmap block allocator: tracks the pool and compares every result
module tlba_result_check
	import tlba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  req_t              req,
	input  logic              done,
	input  rsp_t              rsp,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [ADDR_W-1:0] cfg_wdata,
	output int                errors,
	output int                outstanding,
	output int                n_ok,
	output int                n_empty,
	output int                n_range,
	output int                n_double
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_CAP = (NUM_GROUPS_DEF * WORD_W < MAX_BLOCKS_DEF) ?
		NUM_GROUPS_DEF * WORD_W : MAX_BLOCKS_DEF;

	logic [ADDR_W-1:0] base_r;
	logic [SIZE_W-1:0] size_r;
	logic [CNT_W-1:0]  count_r;
	logic [WORD_W-1:0] summary;
	logic [WORD_W-1:0] words [NUM_GROUPS_DEF];
	logic [CNT_W-1:0]  nfree;
	rsp_t              pending_rsp [$];
	rsp_t              want;
	int                fails;
	int                tally [4];

	function automatic int live_blocks();
		return (int'(count_r) > POOL_CAP) ? POOL_CAP : int'(count_r);
	endfunction

	function automatic int top_set(input logic [WORD_W-1:0] w);
		int i;
		i = WORD_W - 1;
		while (i > 0 && !w[i]) begin
			i--;
		end
		return i;
	endfunction

	// blocks below the count free, all others in use
	function automatic void load_pool();
		int n;
		int first;
		n = live_blocks();
		summary = '0;
		for (int g = 0; g < NUM_GROUPS_DEF; g++) begin
			first = g * WORD_W;
			if (n >= first + WORD_W) begin
				words[g] = '1;
			end else if (n > first) begin
				words[g] = (WORD_W'(1) << (n - first)) - WORD_W'(1);
			end else begin
				words[g] = '0;
			end
			if (words[g] != '0) begin
				summary[g] = 1'b1;
			end
		end
		nfree = CNT_W'(n);
	endfunction

	function automatic rsp_t serve_request(input req_t r);
		rsp_t              o;
		int                g;
		int                b;
		logic [ADDR_W-1:0] sz;
		logic [ADDR_W-1:0] q;
		o.status = ST_OK;
		o.blk_addr = '0;
		sz = (size_r == '0) ? ADDR_W'(1) : ADDR_W'(size_r);
		if (r.cmd == CMD_ALLOC) begin
			if (summary == '0) begin
				o.status = ST_EMPTY;
			end else begin
				g = top_set(summary);
				b = top_set(words[g]);
				words[g][b] = 1'b0;
				if (words[g] == '0) begin
					summary[g] = 1'b0;
				end
				if (nfree != '0) begin
					nfree--;
				end
				o.blk_addr = base_r + sz * ADDR_W'(g * WORD_W + b);
			end
		end else begin
			q = (r.free_address - base_r) / sz;
			if (q >= ADDR_W'(live_blocks())) begin
				o.status = ST_RANGE;
			end else begin
				g = int'(q[9:5]);
				b = int'(q[4:0]);
				if (words[g][b]) begin
					o.status = ST_DOUBLE;
				end else begin
					words[g][b] = 1'b1;
					summary[g] = 1'b1;
					if (nfree != '1) begin
						nfree++;
					end
				end
			end
		end
		o.free_blocks = nfree;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_r = '0;
			size_r = SIZE_RST;
			count_r = CNT_W'(MAX_BLOCKS_DEF);
			load_pool();
			pending_rsp.delete();
		end else begin
			if (done) begin
				tally[rsp.status] = tally[rsp.status] + 1;
				if (pending_rsp.size() == 0) begin
					if (fails < 10) begin
						$display("%t unexpected result: status %0d addr %h free %0d", $realtime,
							rsp.status, rsp.blk_addr, rsp.free_blocks);
					end
					fails++;
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.status !== want.status || rsp.blk_addr !== want.blk_addr ||
						rsp.free_blocks !== want.free_blocks) begin
						if (fails < 10) begin
							$display("%t mismatch: expected status %0d addr %h free %0d, got status %0d addr %h free %0d",
								$realtime, want.status, want.blk_addr, want.free_blocks,
								rsp.status, rsp.blk_addr, rsp.free_blocks);
						end
						fails++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_POOL_BASE: begin
						base_r = cfg_wdata;
					end
					REG_BLOCK_SIZE: begin
						size_r = cfg_wdata[SIZE_W-1:0];
					end
					REG_BLOCK_COUNT: begin
						count_r = cfg_wdata[CNT_W-1:0];
						load_pool();
					end
					default: begin
					end
				endcase
			end
			if (start && !busy) begin
				pending_rsp.push_back(serve_request(req));
			end
		end
		outstanding <= pending_rsp.size();
		errors <= fails;
		n_ok <= tally[ST_OK];
		n_empty <= tally[ST_EMPTY];
		n_range <= tally[ST_RANGE];
		n_double <= tally[ST_DOUBLE];
	end

endmodule

### test/tb_two_level_bitmap_block_allocator.sv
// top testbench of the two-level bitmap block allocator: reset, pool setups, requests and verdict
module tb_two_level_bitmap_block_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import tlba_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 122;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	req_t              req = '0;
	logic              done;
	rsp_t              rsp;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_idx = '0;
	logic [ADDR_W-1:0] cfg_wdata = '0;

	int errors;
	int outstanding;
	int n_ok;
	int n_empty;
	int n_range;
	int n_double;

	logic [ADDR_W-1:0] cur_base = '0;
	logic [SIZE_W-1:0] cur_size = SIZE_RST;
	logic [CNT_W-1:0]  cur_count = CNT_W'(MAX_BLOCKS_DEF);
	cmd_t              last_cmd = CMD_ALLOC;
	int                live_idx [$];
	int                quiet;
	int                n_sent;
	int                n_setups;

	always #5 clk = ~clk;

	two_level_bitmap_block_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	tlba_result_check result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.errors      (errors),
		.outstanding (outstanding),
		.n_ok        (n_ok),
		.n_empty     (n_empty),
		.n_range     (n_range),
		.n_double    (n_double)
	);

	function automatic logic [ADDR_W-1:0] step_size();
		return (cur_size == '0) ? ADDR_W'(1) : ADDR_W'(cur_size);
	endfunction

	function automatic int pool_blocks();
		return (int'(cur_count) > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(cur_count);
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(3, 1);
		end else if (r < 95) begin
			return $urandom_range(12, 4);
		end
		return $urandom_range(60, 20);
	endfunction

	// remember granted blocks so that later frees can return them
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet = 0;
		end else begin
			if (start && !busy) begin
				last_cmd <= req.cmd;
			end
			if (done && rsp.status == ST_OK && last_cmd == CMD_ALLOC) begin
				live_idx.push_back(int'((rsp.blk_addr - cur_base) / step_size()));
			end
			if ((start && !busy) || done || cfg_we) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("two_level_bitmap_block_allocator regression: fail");
					$finish;
				end
			end
		end
	end

	task automatic pause(input int n);
		req_t junk;
		if (n > 0) begin
			junk.cmd = cmd_t'($urandom_range(1));
			junk.free_address = $urandom();
			start <= 1'b0;
			req <= junk;
			repeat (n) @(negedge clk);
		end
	endtask

	// hold the request until the transfer, then leave a gap
	task automatic send(input cmd_t c, input logic [ADDR_W-1:0] a, input int gap);
		req_t item;
		item.cmd = c;
		item.free_address = a;
		start <= 1'b1;
		req <= item;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		@(negedge clk);
		n_sent++;
		pause(gap);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [ADDR_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_wdata <= v;
		@(negedge clk);
	endtask

	task automatic program_pool(input logic [ADDR_W-1:0] b, input logic [SIZE_W-1:0] s,
		input logic [CNT_W-1:0] c, input bit reload);
		settle();
		write_reg(REG_POOL_BASE, b);
		write_reg(REG_BLOCK_SIZE, ADDR_W'(s));
		if (reload) begin
			write_reg(REG_BLOCK_COUNT, ADDR_W'(c));
		end
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_base = b;
		cur_size = s;
		if (reload) begin
			cur_count = c;
			live_idx.delete();
		end
		n_setups++;
	endtask

	initial begin
		logic [ADDR_W-1:0] base_v;
		logic [SIZE_W-1:0] size_v;
		logic [CNT_W-1:0]  count_v;
		logic [ADDR_W-1:0] idx;
		logic [ADDR_W-1:0] addr;
		bit                reload;
		bit                no_gaps;
		int                alloc_pct;
		int                run_left;
		int                r;
		int                k;
		cmd_t              c;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// pool as it comes out of reset
		send(CMD_ALLOC, 32'h0, $urandom_range(2));
		send(CMD_FREE, 32'd32767, $urandom_range(2));
		send(CMD_FREE, 32'd32736, $urandom_range(2));
		send(CMD_FREE, 32'd32768, $urandom_range(2));
		send(CMD_FREE, 32'hFFFF_FFFF, $urandom_range(2));
		send(CMD_FREE, 32'h0, $urandom_range(2));
		send(CMD_ALLOC, 32'hFFFF_FFFF, $urandom_range(2));
		send(CMD_ALLOC, 32'h5555_AAAA, $urandom_range(2));

		// zero size, tiny pool, base near the top of the address space
		program_pool(32'hFFFF_FF00, '0, CNT_W'(3), 1'b1);
		repeat (4) send(CMD_ALLOC, 32'h0, $urandom_range(2));
		send(CMD_FREE, 32'hFFFF_FF01, $urandom_range(2));
		send(CMD_FREE, 32'hFFFF_FF01, $urandom_range(2));
		send(CMD_FREE, 32'hFFFF_FEFF, $urandom_range(2));
		send(CMD_FREE, 32'h0, $urandom_range(2));

		// oversized count saturates, largest size wraps the address
		program_pool(32'hFFFF_F000, SIZE_W'(8191), CNT_W'(2047), 1'b1);
		send(CMD_ALLOC, 32'h0, $urandom_range(2));
		send(CMD_FREE, 32'hFFFF_F000 + 32'd8191 * 32'd1023 + 32'd8190, $urandom_range(2));
		send(CMD_FREE, 32'hFFFF_F000 + 32'd8191 * 32'd1024, $urandom_range(2));

		program_pool(32'hFFFF_FFFF, SIZE_W'(4096), CNT_W'(1), 1'b1);
		send(CMD_ALLOC, 32'h0, $urandom_range(2));
		send(CMD_ALLOC, 32'h0, $urandom_range(2));
		send(CMD_FREE, 32'hFFFF_FFFF + 32'd4095, $urandom_range(2));

		// empty pool
		program_pool(32'h0, SIZE_W'(1), '0, 1'b1);
		send(CMD_ALLOC, 32'h0, $urandom_range(2));
		send(CMD_FREE, 32'h0, $urandom_range(2));

		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(9))
				0, 1: base_v = '0;
				2: base_v = '1;
				3: base_v = 32'hFFFF_F000;
				default: base_v = $urandom();
			endcase
			case ($urandom_range(9))
				0: size_v = '0;
				1: size_v = SIZE_W'(1);
				2: size_v = SIZE_W'(4096);
				3: size_v = SIZE_W'(8191);
				4, 5: size_v = SIZE_RST;
				6, 7: size_v = SIZE_W'($urandom_range(64, 2));
				default: size_v = SIZE_W'($urandom_range(8191));
			endcase
			case ($urandom_range(11))
				0: count_v = '0;
				1: count_v = CNT_W'(1);
				2: count_v = CNT_W'(32);
				3: count_v = CNT_W'(33);
				4: count_v = CNT_W'(1024);
				5: count_v = CNT_W'($urandom_range(2047, 1025));
				6, 7, 8, 9: count_v = CNT_W'($urandom_range(96, 2));
				default: count_v = CNT_W'($urandom_range(1023));
			endcase
			reload = (p == 0) || ($urandom_range(9) < 8);
			no_gaps = ($urandom_range(4) == 0);
			program_pool(base_v, size_v, count_v, reload);

			run_left = 0;
			alloc_pct = 50;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (run_left == 0) begin
					run_left = $urandom_range(40, 8);
					case ($urandom_range(2))
						0: alloc_pct = 85;
						1: alloc_pct = 50;
						default: alloc_pct = 20;
					endcase
				end
				run_left--;
				c = ($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
				addr = $urandom();
				if (c == CMD_FREE) begin
					r = $urandom_range(99);
					if (r < 55 && live_idx.size() > 0) begin
						k = $urandom_range(live_idx.size() - 1);
						idx = ADDR_W'(live_idx[k]);
						live_idx.delete(k);
					end else if (r < 80) begin
						idx = ADDR_W'($urandom_range(pool_blocks() > 0 ? pool_blocks() - 1 : 0));
					end else begin
						idx = ADDR_W'(pool_blocks() + $urandom_range(40));
					end
					// anywhere inside the block, or a random address now and then
					addr = cur_base + step_size() * idx + ADDR_W'($urandom_range(step_size() - 1));
					if (r >= 92) begin
						addr = $urandom();
					end
				end
				send(c, addr, no_gaps ? 0 : gap_len());
			end
		end

		settle();
		$display("ran %0d requests over %0d pool setups: extremes of base, size and count,",
			n_sent, n_setups);
		$display("results %0d ok, %0d pool empty, %0d out of range, %0d already free",
			n_ok, n_empty, n_range, n_double);
		if (errors == 0 && outstanding == 0) begin
			$display("two_level_bitmap_block_allocator regression: pass");
		end else begin
			$display("two_level_bitmap_block_allocator regression: fail");
		end
		$finish;
	end

endmodule

### two_level_bitmap_block_allocator.f
rtl/tlba_pkg.sv
rtl/tlba_div.sv
rtl/two_level_bitmap_block_allocator.sv
test/tlba_result_check.sv
test/tb_two_level_bitmap_block_allocator.sv
